@@ rtl/label_bounding_box_table_core_macros.svh @@
// assertion macros used by the label bounding box table core
`ifndef LABEL_BOUNDING_BOX_TABLE_CORE_MACROS_SVH
`define LABEL_BOUNDING_BOX_TABLE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LBBT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LBBT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lbbt_pkg.sv @@
// shared types and constants for the label bounding box table
package lbbt_pkg;

    // fixed field widths of the item channels
    localparam int FIELD_BITS = 12;
    localparam int SIZE_BITS  = 24;

    // defaults for the top level parameters
    localparam int LABEL_COUNT_DEF = 4096;
    localparam int COORD_BITS_DEF  = 12;

    // saturation value of the box size
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

    // command codes
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // request item
    typedef struct packed {
        logic                  command;
        logic [FIELD_BITS-1:0] label;
        logic [FIELD_BITS-1:0] column;
        logic [FIELD_BITS-1:0] row;
    } req_item_t;

    // response item
    typedef struct packed {
        logic                  present;
        logic [FIELD_BITS-1:0] left;
        logic [FIELD_BITS-1:0] top;
        logic [FIELD_BITS-1:0] right;
        logic [FIELD_BITS-1:0] bottom;
        logic [SIZE_BITS-1:0]  box_size;
    } rsp_item_t;

endpackage

@@ rtl/lbbt_store.sv @@
// box memory with registered read port and clearing sweep after reset
module lbbt_store
    import lbbt_pkg::*;
#(
    parameter int LABEL_COUNT = LABEL_COUNT_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    localparam int LABEL_BITS = $clog2(LABEL_COUNT),
    localparam int ENTRY_W    = 1 + 4 * COORD_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [LABEL_BITS-1:0] rd_addr,
    output logic [ENTRY_W-1:0]    rd_data,
    input  logic                  wr_en,
    input  logic [LABEL_BITS-1:0] wr_addr,
    input  logic [ENTRY_W-1:0]    wr_data,
    output logic                  clearing
);

    logic [ENTRY_W-1:0]    mem [LABEL_COUNT];
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  clear_reg;
    logic                  clear_next;
    logic [LABEL_BITS-1:0] clr_cnt_reg;
    logic [LABEL_BITS-1:0] clr_cnt_next;
    logic                  mem_we;
    logic [LABEL_BITS-1:0] mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;

    // sweep counter, one entry a cycle
    always_comb
    begin
        clear_next   = clear_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clear_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LABEL_BITS'(LABEL_COUNT - 1))
            begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg   <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            clear_reg   <= clear_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // write port shared by sweep and pipeline
    always_comb
    begin
        if (clear_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    // memory array, read before write
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clear_reg;

endmodule

@@ rtl/lbbt_merge.sv @@
// forwarding select and min/max widening of one box entry
module lbbt_merge
    import lbbt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int ENTRY_W   = 1 + 4 * COORD_BITS
)
(
    input  logic [ENTRY_W-1:0]    rd_entry,
    input  logic                  fwd_hit,
    input  logic [ENTRY_W-1:0]    fwd_entry,
    input  logic [COORD_BITS-1:0] column,
    input  logic [COORD_BITS-1:0] row,
    output logic [ENTRY_W-1:0]    merged,
    output logic                  cur_present,
    output logic [COORD_BITS-1:0] cur_left,
    output logic [COORD_BITS-1:0] cur_top,
    output logic [COORD_BITS-1:0] cur_right,
    output logic [COORD_BITS-1:0] cur_bottom,
    output logic [COORD_BITS-1:0] width,
    output logic [COORD_BITS-1:0] height
);

    logic [ENTRY_W-1:0]    cur;
    logic [COORD_BITS-1:0] new_left;
    logic [COORD_BITS-1:0] new_top;
    logic [COORD_BITS-1:0] new_right;
    logic [COORD_BITS-1:0] new_bottom;

    // newest copy of the entry
    assign cur         = fwd_hit ? fwd_entry : rd_entry;
    assign cur_present = cur[ENTRY_W-1];
    assign cur_left    = cur[4*COORD_BITS-1:3*COORD_BITS];
    assign cur_top     = cur[3*COORD_BITS-1:2*COORD_BITS];
    assign cur_right   = cur[2*COORD_BITS-1:COORD_BITS];
    assign cur_bottom  = cur[COORD_BITS-1:0];

    // extent for the size product
    assign width  = cur_right - cur_left;
    assign height = cur_bottom - cur_top;

    // first pixel sets a point, later ones widen the box
    always_comb
    begin
        if (!cur_present)
        begin
            new_left   = column;
            new_right  = column;
            new_top    = row;
            new_bottom = row;
        end
        else
        begin
            new_left   = (column < cur_left)   ? column : cur_left;
            new_right  = (column > cur_right)  ? column : cur_right;
            new_top    = (row < cur_top)       ? row    : cur_top;
            new_bottom = (row > cur_bottom)    ? row    : cur_bottom;
        end
    end

    assign merged = {1'b1, new_left, new_top, new_right, new_bottom};

endmodule

@@ rtl/lbbt_size.sv @@
// box size multiply stage and response output register
module lbbt_size
    import lbbt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  present,
    input  logic [COORD_BITS-1:0] left,
    input  logic [COORD_BITS-1:0] top,
    input  logic [COORD_BITS-1:0] right,
    input  logic [COORD_BITS-1:0] bottom,
    input  logic [COORD_BITS-1:0] width,
    input  logic [COORD_BITS-1:0] height,
    output logic                  busy,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_item_t             rsp
);

    logic                    s2_valid_reg;
    logic                    s2_valid_next;
    logic                    s2_present_reg;
    logic [COORD_BITS-1:0]   s2_left_reg;
    logic [COORD_BITS-1:0]   s2_top_reg;
    logic [COORD_BITS-1:0]   s2_right_reg;
    logic [COORD_BITS-1:0]   s2_bottom_reg;
    logic [COORD_BITS-1:0]   s2_width_reg;
    logic [COORD_BITS-1:0]   s2_height_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    rsp_item_t               out_reg;
    rsp_item_t               out_next;
    logic                    out_free;
    logic [2*COORD_BITS-1:0] product;
    logic [31:0]             product_wide;

    // output register is free when empty or taken this cycle
    assign out_free = !out_valid_reg || !rsp_stall;
    assign busy     = s2_valid_reg && !out_free;

    // size product with saturation
    assign product      = s2_width_reg * s2_height_reg;
    assign product_wide = 32'(product);

    always_comb
    begin
        out_next = '0;
        if (s2_present_reg)
        begin
            out_next.present = 1'b1;
            out_next.left    = FIELD_BITS'(s2_left_reg);
            out_next.top     = FIELD_BITS'(s2_top_reg);
            out_next.right   = FIELD_BITS'(s2_right_reg);
            out_next.bottom  = FIELD_BITS'(s2_bottom_reg);
            out_next.box_size = (product_wide > 32'(SIZE_MAX)) ? SIZE_MAX
                                                               : product_wide[SIZE_BITS-1:0];
        end
    end

    // valid flags of both stages
    always_comb
    begin
        s2_valid_next  = s2_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s2_valid_reg;
        end
        if (!busy)
        begin
            s2_valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!busy && load)
        begin
            s2_present_reg <= present;
            s2_left_reg    <= left;
            s2_top_reg     <= top;
            s2_right_reg   <= right;
            s2_bottom_reg  <= bottom;
            s2_width_reg   <= width;
            s2_height_reg  <= height;
        end
        if (out_free && s2_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

@@ rtl/label_bounding_box_table_core.sv @@
// Label bounding box table: keeps a min/max box for every segment label.
// The req channel carries items of type req_item_t. An accumulate item
// (command 0) widens the stored box of its label by the pixel's column and
// row and gives no response. A read item (command 1) gives exactly one
// rsp item: present flag, the four box edges and the saturated box size.
// Labels at or above LABEL_COUNT are ignored on accumulate and read back
// as not present.
// Throughput is one item per cycle while req_stall is low: the box memory
// is read at acceptance, the entry is merged in stage one and written
// back, and a forwarding register covers back-to-back items on the same
// label. A read item's response passes from the merge into the multiply
// stage and from there into the output register.
// After reset the memory is swept to empty, one entry per cycle, and
// req_stall stays high until the sweep is done.
// When rsp_stall holds a response, one more read can wait in the multiply
// stage; further items stall only when that stage is also full.
`include "label_bounding_box_table_core_macros.svh"

module label_bounding_box_table_core
    import lbbt_pkg::*;
#(
    parameter int LABEL_COUNT = LABEL_COUNT_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int LABEL_BITS = $clog2(LABEL_COUNT);
    localparam int ENTRY_W    = 1 + 4 * COORD_BITS;

    logic                  clearing;
    logic                  busy;
    logic                  adv;
    logic                  req_accept;
    logic [ENTRY_W-1:0]    rd_data;
    logic                  wr_fire;
    logic                  rd_fire;
    logic [ENTRY_W-1:0]    merged;
    logic                  fwd_hit;
    logic                  cur_present;
    logic [COORD_BITS-1:0] cur_left;
    logic [COORD_BITS-1:0] cur_top;
    logic [COORD_BITS-1:0] cur_right;
    logic [COORD_BITS-1:0] cur_bottom;
    logic [COORD_BITS-1:0] width;
    logic [COORD_BITS-1:0] height;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_cmd_reg;
    logic                  s1_inrange_reg;
    logic [LABEL_BITS-1:0] s1_addr_reg;
    logic [COORD_BITS-1:0] s1_col_reg;
    logic [COORD_BITS-1:0] s1_row_reg;

    logic                  fwd_valid_reg;
    logic [LABEL_BITS-1:0] fwd_addr_reg;
    logic [ENTRY_W-1:0]    fwd_data_reg;

    // pipeline moves unless a read waits behind a held response
    assign adv        = !busy;
    assign req_stall  = clearing || !adv;
    assign req_accept = req_valid && !req_stall;

    // stage one handshake
    assign wr_fire = adv && s1_valid_reg && (s1_cmd_reg == CMD_ACCUM) && s1_inrange_reg;
    assign rd_fire = adv && s1_valid_reg && (s1_cmd_reg == CMD_READ);
    assign fwd_hit = fwd_valid_reg && (fwd_addr_reg == s1_addr_reg);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (adv)
        begin
            s1_valid_next = req_accept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (wr_fire)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // stage one payload and last write for forwarding
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_cmd_reg     <= req.command;
            s1_inrange_reg <= (32'(req.label) < 32'(LABEL_COUNT));
            s1_addr_reg    <= LABEL_BITS'(req.label);
            s1_col_reg     <= COORD_BITS'(req.column);
            s1_row_reg     <= COORD_BITS'(req.row);
        end
        if (wr_fire)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= merged;
        end
    end

    // box memory
    lbbt_store #(
        .LABEL_COUNT (LABEL_COUNT),
        .COORD_BITS  (COORD_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (req_accept),
        .rd_addr  (LABEL_BITS'(req.label)),
        .rd_data  (rd_data),
        .wr_en    (wr_fire),
        .wr_addr  (s1_addr_reg),
        .wr_data  (merged),
        .clearing (clearing)
    );

    // entry update
    lbbt_merge #(
        .COORD_BITS (COORD_BITS)
    ) u_merge (
        .rd_entry    (rd_data),
        .fwd_hit     (fwd_hit),
        .fwd_entry   (fwd_data_reg),
        .column      (s1_col_reg),
        .row         (s1_row_reg),
        .merged      (merged),
        .cur_present (cur_present),
        .cur_left    (cur_left),
        .cur_top     (cur_top),
        .cur_right   (cur_right),
        .cur_bottom  (cur_bottom),
        .width       (width),
        .height      (height)
    );

    // size product and response register
    lbbt_size #(
        .COORD_BITS (COORD_BITS)
    ) u_size (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (rd_fire),
        .present   (cur_present && s1_inrange_reg),
        .left      (cur_left),
        .top       (cur_top),
        .right     (cur_right),
        .bottom    (cur_bottom),
        .width     (width),
        .height    (height),
        .busy      (busy),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // checks
    `LBBT_ASSERT_IMP(a_no_write_in_sweep, clearing, !wr_fire,
        "pipeline write during memory sweep")
    `LBBT_ASSERT_IMP(a_write_marks_present, wr_fire, merged[ENTRY_W-1],
        "write without present bit")
    `LBBT_ASSERT_NXT(a_stage_holds, s1_valid_reg && !adv,
        s1_valid_reg && $stable(s1_addr_reg), "stage one lost its item while held")
    `LBBT_ASSERT_NXT(a_fwd_tracks_write, wr_fire,
        fwd_valid_reg && (fwd_addr_reg == $past(s1_addr_reg)),
        "forwarding register missed a write")

endmodule
